>>> hdl/lgc_pkg.sv
package lgc_pkg;

  // operation codes
  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_TICK   = 2'd1;
  localparam logic [1:0] OP_SAMPLE = 2'd2;

  localparam int unsigned IdxW    = 7;
  localparam int unsigned CntW    = 8;
  localparam int unsigned SampleW = 12;
  localparam int unsigned PixelW  = 16;
  localparam int unsigned GainW   = 16;
  localparam int unsigned GainFrac = 14;

  // per-request control results carried down the pipe
  typedef struct packed {
    logic             clk_level;
    logic             si_pulse;
    logic             adc_start;
    logic             busy_res;
    logic             line_done;
    logic             pixel_valid;
    logic [IdxW-1:0]  pixel_index;
  } lgc_ctrl_t;

  // left half of the Q2.14 cosine gain curve, center at entry 63
  localparam logic [GainW-1:0] GAIN_HALF [64] = '{
    16'd21388, 16'd21194, 16'd21005, 16'd20823, 16'd20646, 16'd20475, 16'd20309, 16'd20148,
    16'd19992, 16'd19840, 16'd19694, 16'd19551, 16'd19414, 16'd19280, 16'd19151, 16'd19025,
    16'd18904, 16'd18786, 16'd18672, 16'd18561, 16'd18455, 16'd18351, 16'd18251, 16'd18154,
    16'd18060, 16'd17970, 16'd17882, 16'd17798, 16'd17716, 16'd17638, 16'd17562, 16'd17489,
    16'd17418, 16'd17350, 16'd17285, 16'd17223, 16'd17162, 16'd17105, 16'd17050, 16'd16997,
    16'd16946, 16'd16898, 16'd16853, 16'd16809, 16'd16768, 16'd16729, 16'd16692, 16'd16657,
    16'd16625, 16'd16594, 16'd16566, 16'd16540, 16'd16516, 16'd16494, 16'd16474, 16'd16456,
    16'd16440, 16'd16426, 16'd16414, 16'd16404, 16'd16396, 16'd16390, 16'd16386, 16'd16384
  };

  // full 128-entry table, mirrored about the line center
  function automatic logic [GainW-1:0] gain_of(input logic [IdxW-1:0] idx);
    logic [5:0] half_idx;
    half_idx = idx[6] ? ~idx[5:0] : idx[5:0];
    return GAIN_HALF[half_idx];
  endfunction

endpackage

>>> hdl/lgc_if.sv
interface lgc_in_if;
  import lgc_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic [SampleW-1:0] adc_sample;

  modport source (output valid, output operation, output adc_sample, input ready);
  modport sink   (input valid, input operation, input adc_sample, output ready);
endinterface

interface lgc_out_if;
  import lgc_pkg::*;
  logic              valid;
  logic              ready;
  logic              clk_level;
  logic              si_pulse;
  logic              adc_start;
  logic              busy_res;
  logic              line_done;
  logic              pixel_valid;
  logic [IdxW-1:0]   pixel_index;
  logic [PixelW-1:0] pixel_value;

  modport source (output valid, output clk_level, output si_pulse, output adc_start,
                  output busy_res, output line_done, output pixel_valid,
                  output pixel_index, output pixel_value, input ready);
  modport sink   (input valid, input clk_level, input si_pulse, input adc_start,
                  input busy_res, input line_done, input pixel_valid,
                  input pixel_index, input pixel_value, output ready);
endinterface

>>> hdl/linescan_readout_gain_correct_core.sv
// pipeline: two register stages; a request is registered in stage one alongside the
//   ROM read, then in the output register once that register is free
// throughput: one request per cycle while the output is not stalled; the gain ROM
//   read and the multiplier are pipelined, so output back-pressure sets the pace
// reset: rst_ni asynchronous, active low; clears sequencer state and pipeline
//   valids, gain table is constant and needs no clearing pass
module linescan_readout_gain_correct_core #(
  parameter int PIXELS      = 128,
  parameter int CLOCK_LIMIT = 128
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lgc_in_if.sink     in_i,
  lgc_out_if.source  out_o
);
  import lgc_pkg::*;

  logic               accept;
  logic               out_free;
  logic               s1_adv;
  lgc_ctrl_t          seq_ctrl;
  logic [IdxW-1:0]    rom_addr;
  logic [GainW-1:0]   gain;
  logic               s1_valid_q;
  lgc_ctrl_t          s1_ctrl_q;
  logic [SampleW-1:0] s1_sample_q;
  logic               out_valid;
  lgc_ctrl_t          out_ctrl;
  logic [PixelW-1:0]  out_value;

  // pipeline flow control
  assign out_free = !out_valid || out_o.ready;
  assign s1_adv   = !s1_valid_q || out_free;
  assign in_i.ready = s1_adv;
  assign accept   = in_i.valid && s1_adv;

  lgc_seq #(
    .PIXELS      (PIXELS),
    .CLOCK_LIMIT (CLOCK_LIMIT)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .operation_i (in_i.operation),
    .ctrl_o      (seq_ctrl),
    .rom_addr_o  (rom_addr)
  );

  lgc_gain_rom u_rom (
    .clk_i  (clk_i),
    .en_i   (accept),
    .addr_i (rom_addr),
    .data_o (gain)
  );

  // stage one alongside the ROM read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_ctrl_q   <= seq_ctrl;
      s1_sample_q <= in_i.adc_sample;
    end
  end

  lgc_scale u_scale (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (out_free),
    .valid_i  (s1_valid_q),
    .ctrl_i   (s1_ctrl_q),
    .sample_i (s1_sample_q),
    .gain_i   (gain),
    .valid_o  (out_valid),
    .ctrl_o   (out_ctrl),
    .value_o  (out_value)
  );

  assign out_o.valid       = out_valid;
  assign out_o.clk_level   = out_ctrl.clk_level;
  assign out_o.si_pulse    = out_ctrl.si_pulse;
  assign out_o.adc_start   = out_ctrl.adc_start;
  assign out_o.busy_res    = out_ctrl.busy_res;
  assign out_o.line_done   = out_ctrl.line_done;
  assign out_o.pixel_valid = out_ctrl.pixel_valid;
  assign out_o.pixel_index = out_ctrl.pixel_index;
  assign out_o.pixel_value = out_value;

endmodule

>>> hdl/lgc_seq.sv
module lgc_seq #(
  parameter int PIXELS      = 128,
  parameter int CLOCK_LIMIT = 128
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  logic [1:0]                 operation_i,
  output lgc_pkg::lgc_ctrl_t         ctrl_o,
  output logic [lgc_pkg::IdxW-1:0]   rom_addr_o
);
  import lgc_pkg::*;

  localparam logic [CntW-1:0] PixLim   = CntW'(PIXELS);
  localparam logic [CntW-1:0] ClockLim = CntW'(CLOCK_LIMIT);
  localparam logic [CntW-1:0] CntMax   = '1;

  logic            clk_high_q, clk_high_d;
  logic            scan_q, scan_d;
  logic [CntW-1:0] edges_q, edges_d;
  logic [CntW-1:0] taken_q, taken_d;

  // next state and per-request flags
  always_comb begin
    clk_high_d = clk_high_q;
    scan_d     = scan_q;
    edges_d    = edges_q;
    taken_d    = taken_q;
    ctrl_o     = '0;
    unique case (operation_i)
      OP_START: begin
        scan_d          = 1'b1;
        clk_high_d      = 1'b1;
        edges_d         = '0;
        taken_d         = '0;
        ctrl_o.si_pulse = 1'b1;
      end
      OP_TICK: begin
        if (scan_q) begin
          if (!clk_high_q) begin
            if (edges_q != CntMax) begin
              edges_d = edges_q + 1'b1;
            end
            if (edges_q >= ClockLim) begin
              scan_d           = 1'b0;
              ctrl_o.line_done = 1'b1;
            end else begin
              clk_high_d = 1'b1;
            end
          end else begin
            clk_high_d       = 1'b0;
            ctrl_o.adc_start = 1'b1;
          end
        end
      end
      OP_SAMPLE: begin
        if (taken_q < PixLim) begin
          ctrl_o.pixel_valid = 1'b1;
          ctrl_o.pixel_index = taken_q[IdxW-1:0];
          taken_d            = taken_q + 1'b1;
        end
      end
      default: begin
      end
    endcase
    ctrl_o.clk_level = clk_high_d;
    ctrl_o.busy_res  = scan_d;
  end

  assign rom_addr_o = taken_q[IdxW-1:0];

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clk_high_q <= 1'b0;
      scan_q     <= 1'b0;
      edges_q    <= '0;
      taken_q    <= '0;
    end else if (accept_i) begin
      clk_high_q <= clk_high_d;
      scan_q     <= scan_d;
      edges_q    <= edges_d;
      taken_q    <= taken_d;
    end
  end

endmodule

>>> hdl/lgc_gain_rom.sv
module lgc_gain_rom (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [lgc_pkg::IdxW-1:0]    addr_i,
  output logic [lgc_pkg::GainW-1:0]   data_o
);
  import lgc_pkg::*;

  logic [GainW-1:0] data_q;

  // synchronous read, data holds while stalled
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= gain_of(addr_i);
    end
  end

  assign data_o = data_q;

endmodule

>>> hdl/lgc_scale.sv
module lgc_scale (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          load_i,
  input  logic                          valid_i,
  input  lgc_pkg::lgc_ctrl_t            ctrl_i,
  input  logic [lgc_pkg::SampleW-1:0]   sample_i,
  input  logic [lgc_pkg::GainW-1:0]     gain_i,
  output logic                          valid_o,
  output lgc_pkg::lgc_ctrl_t            ctrl_o,
  output logic [lgc_pkg::PixelW-1:0]    value_o
);
  import lgc_pkg::*;

  localparam int unsigned ProdW = PixelW + GainW;

  logic [PixelW-1:0] widened;
  logic [ProdW-1:0]  prod;
  logic [ProdW-GainFrac-1:0] scaled;
  logic [PixelW-1:0] value_d;
  logic              valid_q;
  lgc_ctrl_t         ctrl_q;
  logic [PixelW-1:0] value_q;

  // widen, multiply by Q2.14 gain, truncate and saturate; non-pixel results are zero
  always_comb begin
    widened = {sample_i, 4'b0000};
    prod    = ProdW'(widened) * ProdW'(gain_i);
    scaled  = prod[ProdW-1:GainFrac];
    if (!ctrl_i.pixel_valid) begin
      value_d = '0;
    end else if (scaled[ProdW-GainFrac-1:PixelW] != '0) begin
      value_d = '1;
    end else begin
      value_d = scaled[PixelW-1:0];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ctrl_q  <= ctrl_i;
      value_q <= value_d;
    end
  end

  assign valid_o = valid_q;
  assign ctrl_o  = ctrl_q;
  assign value_o = value_q;

endmodule

>>> hdl/lgc_checker.sv
module lgc_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic                        clk_level_i,
  input logic                        si_pulse_i,
  input logic                        adc_start_i,
  input logic                        busy_res_i,
  input logic                        line_done_i,
  input logic                        pixel_valid_i,
  input logic [lgc_pkg::IdxW-1:0]    pixel_index_i,
  input logic [lgc_pkg::PixelW-1:0]  pixel_value_i
);

  // a stalled result keeps its payload
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(pixel_value_i)
      && $stable(pixel_index_i) && $stable(clk_level_i) && $stable(busy_res_i))
    else $error("stalled result changed");

  // start leaves the clock high and the line busy
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && si_pulse_i |-> clk_level_i && busy_res_i && !line_done_i)
    else $error("start result inconsistent");

  // end of line leaves clock low and scan idle
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && line_done_i |-> !clk_level_i && !busy_res_i && !adc_start_i)
    else $error("line end result inconsistent");

  // conversion start only on a falling edge during a scan
  a_adc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && adc_start_i |-> !clk_level_i && busy_res_i && !pixel_valid_i)
    else $error("conversion start inconsistent");

  // no pixel means zero index and value
  a_pix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !pixel_valid_i |-> pixel_index_i == '0 && pixel_value_i == '0)
    else $error("empty pixel carries data");

endmodule

bind linescan_readout_gain_correct_core lgc_checker u_lgc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .clk_level_i   (out_o.clk_level),
  .si_pulse_i    (out_o.si_pulse),
  .adc_start_i   (out_o.adc_start),
  .busy_res_i    (out_o.busy_res),
  .line_done_i   (out_o.line_done),
  .pixel_valid_i (out_o.pixel_valid),
  .pixel_index_i (out_o.pixel_index),
  .pixel_value_i (out_o.pixel_value)
);

>>> dv/linescan_readout_gain_correct_core_test.sv
`timescale 1ns / 100ps

module linescan_readout_gain_correct_core_test;
  import lgc_pkg::*;

  localparam int PIXELS      = 128;
  localparam int CLOCK_LIMIT = 128;
  localparam int HOLD_CYCLES = 70;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 30;
  localparam int FULL_LINE_CAP = 4 * CLOCK_LIMIT + 2 * PIXELS + 64;
  localparam int MAX_REPORTS = 50;

  // operation code with no effect on the sequencer
  localparam logic [1:0] OP_NOP = 2'd3;

  // expected readout of one request
  typedef struct packed {
    logic              clk_level;
    logic              si_pulse;
    logic              adc_start;
    logic              busy_res;
    logic              line_done;
    logic              pixel_valid;
    logic [IdxW-1:0]   pixel_index;
    logic [PixelW-1:0] pixel_value;
  } readout_t;

  // left half of the lens gain curve in Q2.14, mirrored about the line center
  localparam logic [15:0] LENS_GAIN_HALF [64] = '{
    16'd21388, 16'd21194, 16'd21005, 16'd20823, 16'd20646, 16'd20475, 16'd20309, 16'd20148,
    16'd19992, 16'd19840, 16'd19694, 16'd19551, 16'd19414, 16'd19280, 16'd19151, 16'd19025,
    16'd18904, 16'd18786, 16'd18672, 16'd18561, 16'd18455, 16'd18351, 16'd18251, 16'd18154,
    16'd18060, 16'd17970, 16'd17882, 16'd17798, 16'd17716, 16'd17638, 16'd17562, 16'd17489,
    16'd17418, 16'd17350, 16'd17285, 16'd17223, 16'd17162, 16'd17105, 16'd17050, 16'd16997,
    16'd16946, 16'd16898, 16'd16853, 16'd16809, 16'd16768, 16'd16729, 16'd16692, 16'd16657,
    16'd16625, 16'd16594, 16'd16566, 16'd16540, 16'd16516, 16'd16494, 16'd16474, 16'd16456,
    16'd16440, 16'd16426, 16'd16414, 16'd16404, 16'd16396, 16'd16390, 16'd16386, 16'd16384
  };

  logic clk_i;
  logic rst_ni;

  lgc_in_if  in_if ();
  lgc_out_if out_if ();

  linescan_readout_gain_correct_core #(
    .PIXELS      (PIXELS),
    .CLOCK_LIMIT (CLOCK_LIMIT)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // sequencer state as predicted
  logic       line_clock_high;
  logic [7:0] clock_edge_count;
  logic [7:0] pixel_count;
  logic       line_active;

  readout_t expected_readouts [$];

  int mismatches;
  int requests_sent;
  int lines_finished;
  int pixels_corrected;
  int samples_dropped;
  int pixels_saturated;
  int longest_input_stall;
  int cycle_count;
  int src_idle_pct;
  int sink_idle_pct;
  int hold_seq;
  int hold_seen;
  int hold_left;

  // clock and cycle watchdog
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_readouts.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // predict the readout of one accepted request and advance the sequencer
  function automatic readout_t predict_readout(input logic [1:0] op,
                                               input logic [SampleW-1:0] smp);
    readout_t   r;
    logic [7:0] edges_seen;
    logic [6:0] idx;
    logic [5:0] half_idx;
    logic [31:0] prod;
    r = '0;
    case (op)
      OP_START: begin
        line_active      = 1'b1;
        line_clock_high  = 1'b1;
        clock_edge_count = '0;
        pixel_count      = '0;
        r.si_pulse       = 1'b1;
      end
      OP_TICK: begin
        // ticks while idle leave the sequencer alone
        if (line_active) begin
          if (!line_clock_high) begin
            edges_seen = clock_edge_count;
            if (clock_edge_count != 8'hff) clock_edge_count = clock_edge_count + 8'd1;
            if (edges_seen >= CLOCK_LIMIT) begin
              line_active = 1'b0;
              r.line_done = 1'b1;
            end else begin
              line_clock_high = 1'b1;
            end
          end else begin
            line_clock_high = 1'b0;
            r.adc_start     = 1'b1;
          end
        end
      end
      OP_SAMPLE: begin
        // only the pixel count guards a sample, idle or not
        if (pixel_count < PIXELS) begin
          idx      = pixel_count[6:0];
          half_idx = idx[6] ? 6'(7'd127 - idx) : idx[5:0];
          prod     = ((32'(smp) << 4) * 32'(LENS_GAIN_HALF[half_idx])) >> GainFrac;
          if (prod > 32'd65535) prod = 32'd65535;
          r.pixel_valid = 1'b1;
          r.pixel_index = idx;
          r.pixel_value = prod[15:0];
          pixel_count   = pixel_count + 8'd1;
        end
      end
      default: ;
    endcase
    r.clk_level = line_clock_high;
    r.busy_res  = line_active;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
  endtask

  // send one request, optionally after an idle gap, and record its prediction
  task automatic send_request(input logic [1:0] op, input logic [SampleW-1:0] smp);
    readout_t r;
    int       stall;
    stall = 0;
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.operation  <= op;
    in_if.adc_sample <= smp;
    @(posedge clk_i);
    while (!in_if.ready) begin
      stall++;
      @(posedge clk_i);
    end
    if (stall > longest_input_stall) longest_input_stall = stall;
    r = predict_readout(op, smp);
    expected_readouts.push_back(r);
    requests_sent++;
    if (r.line_done) lines_finished++;
    if (r.pixel_valid) pixels_corrected++;
    if (r.pixel_valid && r.pixel_value == 16'hffff) pixels_saturated++;
    if (op == OP_SAMPLE && !r.pixel_valid) samples_dropped++;
  endtask

  function automatic logic [SampleW-1:0] random_sample();
    case ($urandom_range(7))
      0: return '1;
      1: return '0;
      default: return SampleW'($urandom);
    endcase
  endfunction

  // result checker
  always @(posedge clk_i) begin : check_results
    readout_t want;
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready) begin
      if (expected_readouts.size() == 0) begin
        report_mismatch("result with nothing pending, pixel_value", out_if.pixel_value, 0);
      end else begin
        want = expected_readouts.pop_front();
        if (out_if.clk_level !== want.clk_level)
          report_mismatch("clk_level", out_if.clk_level, want.clk_level);
        if (out_if.si_pulse !== want.si_pulse)
          report_mismatch("si_pulse", out_if.si_pulse, want.si_pulse);
        if (out_if.adc_start !== want.adc_start)
          report_mismatch("adc_start", out_if.adc_start, want.adc_start);
        if (out_if.busy_res !== want.busy_res)
          report_mismatch("busy_res", out_if.busy_res, want.busy_res);
        if (out_if.line_done !== want.line_done)
          report_mismatch("line_done", out_if.line_done, want.line_done);
        if (out_if.pixel_valid !== want.pixel_valid)
          report_mismatch("pixel_valid", out_if.pixel_valid, want.pixel_valid);
        if (out_if.pixel_index !== want.pixel_index)
          report_mismatch("pixel_index", out_if.pixel_index, want.pixel_index);
        if (out_if.pixel_value !== want.pixel_value)
          report_mismatch("pixel_value", out_if.pixel_value, want.pixel_value);
      end
    end
  end

  // result receiver: random stalls plus an occasional long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      hold_seen    <= 0;
      hold_left    <= 0;
    end else if (hold_seq != hold_seen) begin
      hold_seen    <= hold_seq;
      hold_left    <= HOLD_CYCLES;
      out_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // extremes, every operation and the corner cases around idle and restart
  task automatic test_directed();
    send_request(OP_NOP, '1);      // unused opcode right after reset
    send_request(OP_TICK, '0);     // tick while idle
    send_request(OP_SAMPLE, '1);   // sample while idle, full scale saturates
    send_request(OP_SAMPLE, '0);
    send_request(OP_START, '1);
    send_request(OP_TICK, '0);     // falling edge requests a conversion
    send_request(OP_SAMPLE, '1);   // counters cleared by start
    send_request(OP_SAMPLE, '0);
    send_request(OP_TICK, '1);     // rising edge
    send_request(OP_NOP, '0);      // unused opcode while scanning
    send_request(OP_SAMPLE, 12'h555);
    send_request(OP_SAMPLE, 12'haaa);
    send_request(OP_START, '0);    // restart in the middle of a line
    send_request(OP_TICK, '0);
    send_request(OP_TICK, '0);
    send_request(OP_SAMPLE, 12'd1);
    send_request(OP_SAMPLE, 12'h800);
    send_request(OP_SAMPLE, 12'h7ff);
    send_request(OP_NOP, '1);
  endtask

  // one line from start toward its end, samples after falling edges;
  // stops early once the request goal is reached or, outside full lines, at a random abort
  task automatic send_line(input int goal, input bit full_line);
    int density;
    int abort_at;
    int ticks;
    int extra;
    density  = (full_line || $urandom_range(1)) ? 100 : $urandom_range(30, 100);
    abort_at = (!full_line && $urandom_range(9) == 0) ? $urandom_range(20, 200) : -1;
    ticks    = 0;
    send_request(OP_START, random_sample());
    while (line_active && requests_sent < goal) begin
      send_request(OP_TICK, random_sample());
      ticks++;
      if (ticks == abort_at) return;
      if (line_active && !line_clock_high && $urandom_range(99) < density)
        send_request(OP_SAMPLE, random_sample());
      if ($urandom_range(99) < 2) send_request(OP_NOP, random_sample());
    end
    if (line_active) return;
    // trailing samples, discarded once the line is full
    extra = $urandom_range(4);
    repeat (extra) send_request(OP_SAMPLE, random_sample());
  endtask

  // random operations, including restarts and the unused opcode
  task automatic send_noise();
    int count;
    count = $urandom_range(8, 24);
    repeat (count) send_request(2'($urandom), random_sample());
  endtask

  task automatic test_random_lines(input int budget);
    int goal;
    goal = requests_sent + budget;
    send_line(goal, 1'b0);
    while (requests_sent < goal) begin
      if ($urandom_range(9) < 7) send_line(goal, 1'b0);
      else send_noise();
    end
  endtask

  // one complete line with a sample after every falling edge, overfilling the line
  task automatic test_full_line();
    send_line(requests_sent + FULL_LINE_CAP, 1'b1);
  endtask

  // receiver holds off long enough for the pipeline to fill and stall the input
  task automatic test_backpressure();
    int prev_src;
    prev_src     = src_idle_pct;
    src_idle_pct = 0;
    hold_seq     <= hold_seq + 1;
    send_request(OP_START, random_sample());
    repeat (20) begin
      send_request(OP_TICK, random_sample());
      send_request(OP_SAMPLE, random_sample());
    end
    src_idle_pct = prev_src;
  endtask

  initial begin
    rst_ni           <= 1'b0;
    in_if.valid      <= 1'b0;
    in_if.operation  <= OP_START;
    in_if.adc_sample <= '0;
    cycle_count      <= 0;
    hold_seq         <= 0;
    sink_idle_pct    <= 47;
    src_idle_pct        = 11;
    mismatches          = 0;
    requests_sent       = 0;
    lines_finished      = 0;
    pixels_corrected    = 0;
    samples_dropped     = 0;
    pixels_saturated    = 0;
    longest_input_stall = 0;
    line_clock_high     = 1'b0;
    clock_edge_count    = '0;
    pixel_count         = '0;
    line_active         = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // sender idles a little, receiver a lot
    test_directed();
    test_random_lines(PHASE_ITEMS);

    // sender idles a lot, receiver a little
    src_idle_pct = 47;
    sink_idle_pct <= 11;
    test_full_line();

    // no idling on either side
    src_idle_pct = 0;
    sink_idle_pct <= 0;
    test_backpressure();
    test_random_lines(PHASE_ITEMS);

    in_if.valid <= 1'b0;
    while (expected_readouts.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("sent %0d requests over %0d cycles: %0d lines ended, %0d pixels corrected",
             requests_sent, cycle_count, lines_finished, pixels_corrected);
    $display("%0d saturated pixels, %0d samples past line end, longest input stall %0d",
             pixels_saturated, samples_dropped, longest_input_stall);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
